// ----- rtl/ica_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ica_pkg
// Shared constants, register indexes and the CORDIC angle table for the
// complementary attitude core.
// ----------------------------------------------------------------------------
package ica_pkg;

  localparam int ICA_CORDIC_STEPS = 16;
  localparam int ICA_ATAN_LEN     = 24;
  localparam int ICA_CW           = 34;
  localparam int ICA_MUL_AW       = 34;
  localparam int ICA_MUL_BW       = 24;
  localparam int ICA_MUL_PW       = ICA_MUL_AW + ICA_MUL_BW;
  localparam int ICA_SQRT_STEPS   = 24;

  localparam logic signed [31:0] ICA_DEG180 = 32'sd11796480;
  localparam logic signed [32:0] ICA_DEG180_W = 33'sd11796480;
  localparam logic signed [32:0] ICA_DEG360_W = 33'sd23592960;
  localparam logic signed [ICA_MUL_BW-1:0] ICA_RAD2DEG = 24'sd3754936;

  localparam logic [2:0] CFG_BLEND_ALPHA = 3'd0;
  localparam logic [2:0] CFG_NORM_MIN_SQ = 3'd1;
  localparam logic [2:0] CFG_NORM_MAX_SQ = 3'd2;
  localparam logic [2:0] CFG_HOME_YAW    = 3'd3;

  localparam logic [16:0] ICA_ALPHA_ONE   = 17'd65536;
  localparam logic [31:0] ICA_MIN_SQ_RST  = 32'd51380224;
  localparam logic [31:0] ICA_MAX_SQ_RST  = 32'd177209344;
  localparam logic [24:0] ICA_HOME_RST    = 25'd5799936;

  function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
    logic signed [31:0] a;
    case (idx)
      5'd0:  a = 32'sd2949120;
      5'd1:  a = 32'sd1740967;
      5'd2:  a = 32'sd919879;
      5'd3:  a = 32'sd466945;
      5'd4:  a = 32'sd234379;
      5'd5:  a = 32'sd117305;
      5'd6:  a = 32'sd58666;
      5'd7:  a = 32'sd29335;
      5'd8:  a = 32'sd14668;
      5'd9:  a = 32'sd7334;
      5'd10: a = 32'sd3667;
      5'd11: a = 32'sd1833;
      5'd12: a = 32'sd917;
      5'd13: a = 32'sd458;
      5'd14: a = 32'sd229;
      5'd15: a = 32'sd115;
      5'd16: a = 32'sd57;
      5'd17: a = 32'sd29;
      5'd18: a = 32'sd14;
      5'd19: a = 32'sd7;
      5'd20: a = 32'sd4;
      5'd21: a = 32'sd2;
      5'd22: a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ica_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ica_cordic
// Iterative CORDIC vectoring unit returning atan2(y, x) in degrees Q16.16.
// ----------------------------------------------------------------------------
module ica_cordic import ica_pkg::*; #(
  parameter int CORDIC_STEPS = ICA_CORDIC_STEPS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [ICA_CW-1:0] y_i,
  input  wire logic signed [ICA_CW-1:0] x_i,
  output logic                          done_o,
  output logic signed [31:0]            z_o
);

  localparam int IW = $clog2(CORDIC_STEPS + 1);
  localparam logic signed [ICA_CW-1:0] LIM29 = ICA_CW'(64'sd536870912);
  localparam logic signed [ICA_CW-1:0] LIM21 = ICA_CW'(64'sd2097152);

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ROT, C_ITER} cstate_e;

  cstate_e                  state_q;
  logic signed [ICA_CW-1:0] x_q, y_q;
  logic signed [31:0]       z_q;
  logic [IW-1:0]            i_q;
  logic                     done_q;

  logic signed [ICA_CW-1:0] xs, ys;
  logic signed [31:0]       ang;
  logic                     small29, small21;

  assign xs      = x_q >>> i_q;
  assign ys      = y_q >>> i_q;
  assign ang     = atan_deg(5'(i_q));
  assign small29 = (x_q < LIM29) && (x_q > -LIM29) && (y_q < LIM29) && (y_q > -LIM29);
  assign small21 = (x_q < LIM21) && (x_q > -LIM21) && (y_q < LIM21) && (y_q > -LIM21);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      i_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            x_q <= x_i;
            y_q <= y_i;
            z_q <= '0;
            i_q <= '0;
            if (x_i == '0 && y_i == '0) begin
              done_q <= 1'b1;
            end else begin
              state_q <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (small29) begin
            if (small21) begin
              x_q <= x_q <<< 8;
              y_q <= y_q <<< 8;
            end else begin
              x_q <= x_q <<< 1;
              y_q <= y_q <<< 1;
            end
          end else begin
            state_q <= C_ROT;
          end
        end
        C_ROT: begin
          if (x_q < 0) begin
            z_q <= (y_q >= 0) ? ICA_DEG180 : -ICA_DEG180;
            x_q <= -x_q;
            y_q <= -y_q;
          end
          state_q <= C_ITER;
        end
        C_ITER: begin
          if (y_q >= 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + ang;
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - ang;
          end
          i_q <= i_q + 1'b1;
          if (i_q == IW'(CORDIC_STEPS - 1)) begin
            state_q <= C_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign z_o    = z_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == C_IDLE) else $error("CORDIC started while busy");
  a_x_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == C_ITER |-> !x_q[ICA_CW-1]) else $error("CORDIC x went negative");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == C_IDLE) else $error("CORDIC done while busy");

endmodule
`default_nettype wire

// ----- rtl/imu_complementary_attitude_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_complementary_attitude_core
// Complementary filter attitude estimator: tilt and heading by a shared
// CORDIC, gyro integration and blending by a shared multiplier.
// ----------------------------------------------------------------------------
// From acceptance the core squares the accel vector and checks its magnitude against the
// window. Outside it, blending follows straight away; inside it, a square root and three
// CORDIC runs (pitch, roll, heading) come first, a zero vector ending its run at once.
// Blending then updates pitch and roll, and the result is registered for output.
// One item at a time: the next item is accepted in the cycle after the result
// is registered, and a stalled result holds the sequence in its final step.
// Reset clears all angle state and loads the register defaults at once.
module imu_complementary_attitude_core import ica_pkg::*; #(
  parameter int CORDIC_STEPS = ICA_CORDIC_STEPS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] gyro_x_i,
  input  wire logic signed [15:0] gyro_y_i,
  input  wire logic signed [15:0] gyro_z_i,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  input  wire logic signed [15:0] mag_x_i,
  input  wire logic signed [15:0] mag_y_i,
  input  wire logic [15:0]        time_step_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      pitch_out_o,
  output logic signed [31:0]      roll_out_o,
  output logic signed [25:0]      yaw_out_o,
  output logic                    accel_ok_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_wdata_i
);

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_SQRT, S_ATAN, S_BLEND, S_DONE} state_e;

  logic [16:0]        alpha_q;
  logic [31:0]        min_sq_q, max_sq_q;
  logic signed [24:0] home_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= '0;
      min_sq_q <= ICA_MIN_SQ_RST;
      max_sq_q <= ICA_MAX_SQ_RST;
      home_q   <= ICA_HOME_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BLEND_ALPHA: alpha_q  <= cfg_wdata_i[16:0];
        CFG_NORM_MIN_SQ: min_sq_q <= cfg_wdata_i;
        CFG_NORM_MAX_SQ: max_sq_q <= cfg_wdata_i;
        CFG_HOME_YAW:    home_q   <= cfg_wdata_i[24:0];
        default: ;
      endcase
    end
  end

  state_e             state_q;
  logic [2:0]         step_q;
  logic [1:0]         phase_q;
  logic               wait_q;
  logic               axis_q;
  logic [4:0]         cnt_q;
  logic               ok_q;
  logic signed [15:0] gx_q, gy_q, ax_q, ay_q, az_q, mx_q, my_q;
  logic [15:0]        dt_q;
  logic [31:0]        yz_q;
  logic [47:0]        rad_q;
  logic [25:0]        rem_q;
  logic [23:0]        root_q;
  logic signed [31:0] tilt_pitch_q, tilt_roll_q, heading_q, pitch_q, roll_q;
  logic signed [ICA_MUL_AW-1:0] sum_q;
  logic signed [ICA_MUL_PW-1:0] acc_q, mul_q;
  logic                out_valid_q, ok_out_q;
  logic signed [31:0]  pitch_out_q, roll_out_q;
  logic signed [25:0]  yaw_out_q;

  logic signed [ICA_MUL_AW-1:0] mul_a;
  logic signed [ICA_MUL_BW-1:0] mul_b;
  logic signed [ICA_MUL_PW-1:0] mul_d;
  logic [16:0]         alpha_eff, one_m;
  logic signed [15:0]  g_sel;
  logic signed [31:0]  prev_sel, tilt_sel;
  logic signed [ICA_MUL_PW-1:0] rnd, acc2, shv;
  logic signed [ICA_MUL_AW-1:0] inc;
  logic signed [31:0]  blend_res;
  logic [31:0]         nsq;
  logic                ok_now;
  logic [27:0]         rem2;
  logic [27:0]         trial;
  logic signed [32:0]  yaw_raw, yaw_w;
  logic                cd_start, cd_done;
  logic signed [ICA_CW-1:0] cd_y, cd_x;
  logic signed [31:0]  cd_z;

  assign alpha_eff = (alpha_q > ICA_ALPHA_ONE) ? ICA_ALPHA_ONE : alpha_q;
  assign one_m     = ICA_ALPHA_ONE - alpha_eff;
  assign g_sel     = axis_q ? gx_q : gy_q;
  assign prev_sel  = axis_q ? roll_q : pitch_q;
  assign tilt_sel  = axis_q ? tilt_roll_q : tilt_pitch_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_SQ) begin
      case (step_q)
        3'd0: begin mul_a = ICA_MUL_AW'(ay_q); mul_b = ICA_MUL_BW'(ay_q); end
        3'd1: begin mul_a = ICA_MUL_AW'(az_q); mul_b = ICA_MUL_BW'(az_q); end
        3'd2: begin mul_a = ICA_MUL_AW'(ax_q); mul_b = ICA_MUL_BW'(ax_q); end
        default: ;
      endcase
    end else if (state_q == S_BLEND) begin
      case (step_q)
        3'd0: begin mul_a = ICA_MUL_AW'(g_sel); mul_b = $signed({8'b0, dt_q}); end
        3'd1: begin mul_a = mul_q[ICA_MUL_AW-1:0]; mul_b = ICA_RAD2DEG; end
        3'd3: begin mul_a = sum_q; mul_b = $signed({7'b0, one_m}); end
        3'd4: begin mul_a = ICA_MUL_AW'(tilt_sel); mul_b = $signed({7'b0, alpha_eff}); end
        default: ;
      endcase
    end
  end

  assign mul_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
  end

  assign nsq    = yz_q + mul_q[31:0];
  assign ok_now = (nsq > min_sq_q) && (nsq < max_sq_q);

  assign rnd  = mul_q + ICA_MUL_PW'(64'sd134217728);
  assign inc  = ICA_MUL_AW'(rnd >>> 28);
  assign acc2 = acc_q + mul_q + ICA_MUL_PW'(64'sd32768);
  assign shv  = acc2 >>> 16;

  always_comb begin
    if (shv > ICA_MUL_PW'(64'sd2147483647)) begin
      blend_res = 32'sh7FFFFFFF;
    end else if (shv < ICA_MUL_PW'(-64'sd2147483648)) begin
      blend_res = 32'sh80000000;
    end else begin
      blend_res = shv[31:0];
    end
  end

  assign rem2  = {rem_q, rad_q[47:46]};
  assign trial = {2'b0, root_q, 2'b01};

  always_comb begin
    case (phase_q)
      2'd0: begin
        cd_y = -(ICA_CW'(ax_q) <<< 8);
        cd_x = $signed({10'b0, root_q});
      end
      2'd1: begin
        cd_y = ICA_CW'(ay_q);
        cd_x = ICA_CW'(az_q);
      end
      default: begin
        cd_y = -ICA_CW'(my_q);
        cd_x = ICA_CW'(mx_q);
      end
    endcase
  end

  assign cd_start = (state_q == S_ATAN) && !wait_q;

  ica_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cd_start),
    .y_i     (cd_y),
    .x_i     (cd_x),
    .done_o  (cd_done),
    .z_o     (cd_z)
  );

  assign yaw_raw = 33'(heading_q) - 33'(home_q);

  always_comb begin
    if (yaw_raw > ICA_DEG180_W) begin
      yaw_w = yaw_raw - ICA_DEG360_W;
    end else if (yaw_raw < -ICA_DEG180_W) begin
      yaw_w = yaw_raw + ICA_DEG360_W;
    end else begin
      yaw_w = yaw_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      gx_q <= gyro_x_i;
      gy_q <= gyro_y_i;
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      mx_q <= mag_x_i;
      my_q <= mag_y_i;
      dt_q <= time_step_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      phase_q      <= '0;
      wait_q       <= 1'b0;
      axis_q       <= 1'b0;
      cnt_q        <= '0;
      ok_q         <= 1'b0;
      yz_q         <= '0;
      rad_q        <= '0;
      rem_q        <= '0;
      root_q       <= '0;
      tilt_pitch_q <= '0;
      tilt_roll_q  <= '0;
      heading_q    <= '0;
      pitch_q      <= '0;
      roll_q       <= '0;
      sum_q        <= '0;
      acc_q        <= '0;
      out_valid_q  <= 1'b0;
      ok_out_q     <= 1'b0;
      pitch_out_q  <= '0;
      roll_out_q   <= '0;
      yaw_out_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SQ;
            step_q  <= '0;
          end
        end
        S_SQ: begin
          step_q <= step_q + 1'b1;
          case (step_q)
            3'd1: yz_q <= mul_q[31:0];
            3'd2: yz_q <= yz_q + mul_q[31:0];
            3'd3: begin
              ok_q   <= ok_now;
              step_q <= '0;
              axis_q <= 1'b0;
              if (ok_now) begin
                state_q <= S_SQRT;
                rad_q   <= {yz_q, 16'b0};
                rem_q   <= '0;
                root_q  <= '0;
                cnt_q   <= '0;
              end else begin
                state_q <= S_BLEND;
              end
            end
            default: ;
          endcase
        end
        S_SQRT: begin
          rad_q <= rad_q << 2;
          if (rem2 >= trial) begin
            rem_q  <= 26'(rem2 - trial);
            root_q <= {root_q[22:0], 1'b1};
          end else begin
            rem_q  <= rem2[25:0];
            root_q <= {root_q[22:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(ICA_SQRT_STEPS - 1)) begin
            state_q <= S_ATAN;
            phase_q <= '0;
            wait_q  <= 1'b0;
          end
        end
        S_ATAN: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (cd_done) begin
            wait_q  <= 1'b0;
            phase_q <= phase_q + 1'b1;
            case (phase_q)
              2'd0: tilt_pitch_q <= cd_z;
              2'd1: tilt_roll_q  <= cd_z;
              default: begin
                heading_q <= cd_z;
                state_q   <= S_BLEND;
                step_q    <= '0;
              end
            endcase
          end
        end
        S_BLEND: begin
          step_q <= step_q + 1'b1;
          case (step_q)
            3'd2: sum_q <= ICA_MUL_AW'(prev_sel) + inc;
            3'd4: acc_q <= mul_q;
            3'd5: begin
              step_q <= '0;
              if (axis_q) begin
                roll_q  <= blend_res;
                state_q <= S_DONE;
              end else begin
                pitch_q <= blend_res;
                axis_q  <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            pitch_out_q <= pitch_q;
            roll_out_q  <= roll_q;
            yaw_out_q   <= yaw_w[25:0];
            ok_out_q    <= ok_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pitch_out_o = pitch_out_q;
  assign roll_out_o  = roll_out_q;
  assign yaw_out_o   = yaw_out_q;
  assign accel_ok_o  = ok_out_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SQ && step_q == 3'd0))
    else $error("Accepted item did not start the sequence");
  a_cordic_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cd_done |-> (state_q == S_ATAN && wait_q))
    else $error("CORDIC result arrived unexpectedly");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("Result shown outside the final step");

endmodule
`default_nettype wire
